/* rtl/core/bbd_pkg.sv */
// shared types, constants and helpers of the billboard basis unit
`timescale 1ns / 1ps

package bbd_pkg;

    localparam int DIR_W             = 32;
    localparam int FIELD_W           = 16;
    localparam int OUT_FRAC_BITS_DEF = 14;
    localparam int SQRT_STEPS        = 32;
    localparam int SHIFT_W           = 5;
    localparam int SQ_W              = 2 * DIR_W;

    typedef struct packed {
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
    } dir_beat_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] fwd_x;
        logic signed [FIELD_W-1:0] fwd_y;
        logic signed [FIELD_W-1:0] fwd_z;
        logic signed [FIELD_W-1:0] side_x;
        logic signed [FIELD_W-1:0] side_y;
        logic                      side_z;
        logic signed [FIELD_W-1:0] up_x;
        logic signed [FIELD_W-1:0] up_y;
        logic signed [FIELD_W-1:0] up_z;
        logic                      degenerate;
    } basis_beat_t;

    // scaled magnitudes and signs carried alongside the square roots
    typedef struct packed {
        logic [DIR_W-1:0] sx;
        logic [DIR_W-1:0] sy;
        logic [DIR_W-1:0] sz;
        logic [DIR_W-1:0] tx;
        logic [DIR_W-1:0] ty;
        logic             nx;
        logic             ny;
        logic             nz;
        logic             degen;
    } geo_t;

    typedef struct packed {
        logic [SQ_W-1:0]  rem3;
        logic [SQ_W-1:0]  rem2;
        logic [DIR_W-1:0] r3;
        logic [DIR_W-1:0] r2;
        geo_t             g;
    } sqrt_t;

    function automatic logic [DIR_W-1:0] mag(input logic signed [DIR_W-1:0] v);
        return unsigned'(v[DIR_W-1] ? -v : v);
    endfunction

    // left shift that brings a nonzero value into [2^30, 2^31]
    function automatic logic [SHIFT_W-1:0] lead_shift(input logic [DIR_W-1:0] m);
        logic [SHIFT_W-1:0] k;
        k = '0;
        for (int i = 0; i < DIR_W - 1; i++)
        begin
            if (m[i])
            begin
                k = SHIFT_W'(DIR_W - 2 - i);
            end
        end
        if (m[DIR_W-1])
        begin
            k = '0;
        end
        return k;
    endfunction

endpackage

/* rtl/core/bbd_stream_if.sv */
// valid/ready stream channel
`timescale 1ns / 1ps

interface bbd_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/billboard_basis_from_direction_unit.sv */
// billboard basis unit: direction in, normalized forward/side/up axes out
//
//   channel  side    payload        beat
//   dir      sink    dir_beat_t     one direction vector
//   basis    source  basis_beat_t   one basis, one per direction
//
// one beat per cycle sustained while basis takes its results; the latency is set by the
// 32-step square root pipeline and the OUT_FRAC_BITS+1 step divide pipeline
// rst_n clears only the valid bits; payload registers are not reset
// when a result waits on basis and is not taken, the whole pipeline holds
`timescale 1ns / 1ps

module billboard_basis_from_direction_unit #(
    parameter int OUT_FRAC_BITS = bbd_pkg::OUT_FRAC_BITS_DEF
) (
    input logic           clk,
    input logic           rst_n,
    bbd_stream_if.sink    dir,
    bbd_stream_if.source  basis
);

    localparam int DW    = bbd_pkg::DIR_W;
    localparam int FW    = bbd_pkg::FIELD_W;
    localparam int SW    = bbd_pkg::SQ_W;
    localparam int NSQ   = bbd_pkg::SQRT_STEPS;
    localparam int OUT   = OUT_FRAC_BITS;
    localparam int QW    = OUT + 1;
    localparam int NW    = DW + OUT + 1;
    localparam int AW    = OUT + 2;
    localparam int PW    = 2 * AW;
    localparam int NSTG  = 40 + QW;
    localparam longint unsigned ONE  = 64'd1 << OUT;
    localparam longint unsigned HALF = 64'd1 << (OUT - 1);

    typedef struct packed {
        logic [4:0][NW-1:0] rem;
        logic [4:0][QW-1:0] q;
        logic [DW-1:0]      den3;
        logic [DW-1:0]      den2;
        logic               nx;
        logic               ny;
        logic               nz;
        logic               degen;
    } div_t;

    function automatic logic signed [AW-1:0] round_sat(input logic signed [PW:0] p);
        logic [PW:0] m;
        logic [PW:0] r;
        m = p[PW] ? unsigned'(-p) : unsigned'(p);
        r = (m + (PW+1)'(HALF)) >> OUT;
        if (r > (PW+1)'(ONE))
        begin
            r = (PW+1)'(ONE);
        end
        return p[PW] ? -AW'(r) : AW'(r);
    endfunction

    logic                 en;
    logic                 accept;
    logic [NSTG-1:0]      vld_reg;
    logic [NSTG-1:0]      vld_next;

    logic [DW-1:0]        ux_reg, uy_reg, uz_reg;
    logic                 nx_reg, ny_reg, nz_reg, dg_reg;
    bbd_pkg::geo_t        geo_reg, geo_next;
    bbd_pkg::geo_t        geo3_reg;
    logic [SW-1:0]        sq_reg [5];
    bbd_pkg::sqrt_t       sqrt_reg [NSQ+1];
    div_t                 div_reg [QW+1];
    div_t                 num_next;
    logic signed [AW-1:0] a_reg [5];
    logic                 dga_reg;
    logic signed [AW-1:0] b_reg [5];
    logic signed [PW-1:0] p_reg [4];
    logic                 dgp_reg;
    bbd_pkg::basis_beat_t out_reg, out_next;

    assign en        = !vld_reg[NSTG-1] || basis.ready;
    assign accept    = dir.valid && en;
    assign dir.ready = en;
    assign vld_next  = {vld_reg[NSTG-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // magnitudes and signs
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ux_reg <= bbd_pkg::mag(dir.data.dir_x);
            uy_reg <= bbd_pkg::mag(dir.data.dir_y);
            uz_reg <= bbd_pkg::mag(dir.data.dir_z);
            nx_reg <= dir.data.dir_x[DW-1];
            ny_reg <= dir.data.dir_y[DW-1];
            nz_reg <= dir.data.dir_z[DW-1];
            dg_reg <= (dir.data.dir_x == '0) && (dir.data.dir_y == '0);
        end
    end

    // common scaling of the 3d and the xy vector
    always_comb
    begin
        logic [DW-1:0] m2;
        logic [DW-1:0] m3;
        logic [bbd_pkg::SHIFT_W-1:0] k3;
        logic [bbd_pkg::SHIFT_W-1:0] k2;
        m2 = (ux_reg > uy_reg) ? ux_reg : uy_reg;
        m3 = (m2 > uz_reg) ? m2 : uz_reg;
        k3 = bbd_pkg::lead_shift(m3);
        k2 = bbd_pkg::lead_shift(m2);
        geo_next.sx    = ux_reg << k3;
        geo_next.sy    = uy_reg << k3;
        geo_next.sz    = uz_reg << k3;
        geo_next.tx    = ux_reg << k2;
        geo_next.ty    = uy_reg << k2;
        geo_next.nx    = nx_reg;
        geo_next.ny    = ny_reg;
        geo_next.nz    = nz_reg;
        geo_next.degen = dg_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geo_reg   <= geo_next;
            sq_reg[0] <= SW'(geo_reg.sx) * SW'(geo_reg.sx);
            sq_reg[1] <= SW'(geo_reg.sy) * SW'(geo_reg.sy);
            sq_reg[2] <= SW'(geo_reg.sz) * SW'(geo_reg.sz);
            sq_reg[3] <= SW'(geo_reg.tx) * SW'(geo_reg.tx);
            sq_reg[4] <= SW'(geo_reg.ty) * SW'(geo_reg.ty);
            geo3_reg  <= geo_reg;
            sqrt_reg[0].rem3 <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            sqrt_reg[0].rem2 <= sq_reg[3] + sq_reg[4];
            sqrt_reg[0].r3   <= '0;
            sqrt_reg[0].r2   <= '0;
            sqrt_reg[0].g    <= geo3_reg;
        end
    end

    // integer square root, one root bit per stage, msb first
    for (genvar j = 0; j < NSQ; j++)
    begin : g_sqrt
        localparam int BI = NSQ - 1 - j;
        bbd_pkg::sqrt_t nxt;
        logic [SW-1:0]  t3;
        logic [SW-1:0]  t2;

        always_comb
        begin
            nxt = sqrt_reg[j];
            t3  = ({{DW{1'b0}}, sqrt_reg[j].r3} << (BI + 1)) | (SW'(1) << (2 * BI));
            t2  = ({{DW{1'b0}}, sqrt_reg[j].r2} << (BI + 1)) | (SW'(1) << (2 * BI));
            if (sqrt_reg[j].rem3 >= t3)
            begin
                nxt.rem3   = sqrt_reg[j].rem3 - t3;
                nxt.r3[BI] = 1'b1;
            end
            if (sqrt_reg[j].rem2 >= t2)
            begin
                nxt.rem2   = sqrt_reg[j].rem2 - t2;
                nxt.r2[BI] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sqrt_reg[j+1] <= nxt;
            end
        end
    end

    // rounded numerators: |v| * 2^OUT + len/2
    always_comb
    begin
        num_next.den3   = sqrt_reg[NSQ].r3;
        num_next.den2   = sqrt_reg[NSQ].r2;
        num_next.rem[0] = (NW'(sqrt_reg[NSQ].g.sx) << OUT) + NW'(sqrt_reg[NSQ].r3 >> 1);
        num_next.rem[1] = (NW'(sqrt_reg[NSQ].g.sy) << OUT) + NW'(sqrt_reg[NSQ].r3 >> 1);
        num_next.rem[2] = (NW'(sqrt_reg[NSQ].g.sz) << OUT) + NW'(sqrt_reg[NSQ].r3 >> 1);
        num_next.rem[3] = (NW'(sqrt_reg[NSQ].g.ty) << OUT) + NW'(sqrt_reg[NSQ].r2 >> 1);
        num_next.rem[4] = (NW'(sqrt_reg[NSQ].g.tx) << OUT) + NW'(sqrt_reg[NSQ].r2 >> 1);
        num_next.q      = '0;
        num_next.nx     = sqrt_reg[NSQ].g.nx;
        num_next.ny     = sqrt_reg[NSQ].g.ny;
        num_next.nz     = sqrt_reg[NSQ].g.nz;
        num_next.degen  = sqrt_reg[NSQ].g.degen;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg[0] <= num_next;
        end
    end

    // restoring divide, one quotient bit per stage for all five lanes
    for (genvar j = 0; j < QW; j++)
    begin : g_div
        localparam int BI = QW - 1 - j;
        div_t nxt;

        always_comb
        begin
            logic [NW-1:0] d;
            nxt = div_reg[j];
            for (int k = 0; k < 5; k++)
            begin
                d = (k < 3) ? (NW'(div_reg[j].den3) << BI) : (NW'(div_reg[j].den2) << BI);
                if (div_reg[j].rem[k] >= d)
                begin
                    nxt.rem[k]   = div_reg[j].rem[k] - d;
                    nxt.q[k][BI] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_reg[j+1] <= nxt;
            end
        end
    end

    // clamp and sign; side x is negative when dir y is positive
    always_ff @(posedge clk)
    begin
        logic [4:0]    neg;
        logic [QW-1:0] q;
        if (en)
        begin
            neg = {div_reg[QW].nx, ~div_reg[QW].ny, div_reg[QW].nz,
                   div_reg[QW].ny, div_reg[QW].nx};
            for (int k = 0; k < 5; k++)
            begin
                q = div_reg[QW].q[k];
                if (q > QW'(ONE))
                begin
                    q = QW'(ONE);
                end
                a_reg[k] <= neg[k] ? -AW'(q) : AW'(q);
            end
            dga_reg <= div_reg[QW].degen;
        end
    end

    // up = fwd x side with side z zero
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= a_reg[4] * a_reg[2];
            p_reg[1] <= a_reg[2] * a_reg[3];
            p_reg[2] <= a_reg[4] * a_reg[0];
            p_reg[3] <= a_reg[3] * a_reg[1];
            b_reg    <= a_reg;
            dgp_reg  <= dga_reg;
        end
    end

    always_comb
    begin
        logic signed [AW-1:0] u0;
        logic signed [AW-1:0] u1;
        logic signed [AW-1:0] u2;
        u0 = round_sat(-((PW+1)'(p_reg[0])));
        u1 = round_sat((PW+1)'(p_reg[1]));
        u2 = round_sat((PW+1)'(p_reg[2]) - (PW+1)'(p_reg[3]));
        out_next            = '0;
        out_next.degenerate = dgp_reg;
        if (!dgp_reg)
        begin
            out_next.fwd_x  = FW'(b_reg[0]);
            out_next.fwd_y  = FW'(b_reg[1]);
            out_next.fwd_z  = FW'(b_reg[2]);
            out_next.side_x = FW'(b_reg[3]);
            out_next.side_y = FW'(b_reg[4]);
            out_next.up_x   = FW'(u0);
            out_next.up_y   = FW'(u1);
            out_next.up_z   = FW'(u2);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign basis.valid = vld_reg[NSTG-1];
    assign basis.data  = out_reg;

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        basis.valid && basis.data.degenerate |->
            basis.data.fwd_x == '0 && basis.data.side_x == '0 && basis.data.up_z == '0)
        else $error("degenerate result carries nonzero axes");

    a_side_z: assert property (@(posedge clk) disable iff (!rst_n)
        basis.valid |-> !basis.data.side_z)
        else $error("side z nonzero");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        dir.valid && dir.ready |=> vld_reg[0])
        else $error("accepted beat lost at pipeline entry");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg) && $stable(out_reg))
        else $error("pipeline moved during stall");

endmodule
